/* hdl/qvr_pkg.sv */
// Shared types, widths and helpers for the quaternion vector rotation pipeline.
// No dependencies.
package qvr_pkg;

  localparam int SampleWidth = 16;
  localparam int ProdWidth   = 32;
  localparam int CoefWidth   = 34;
  localparam int TermWidth   = 50;
  localparam int SumWidth    = 52;
  localparam int FracBits    = 30;
  localparam int RotWidth    = 18;
  localparam int ShiftWidth  = SumWidth - FracBits;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;
  typedef logic signed [CoefWidth-1:0]   coef_t;
  typedef logic signed [TermWidth-1:0]   term_t;
  typedef logic signed [SumWidth-1:0]    sum_t;
  typedef logic signed [ShiftWidth-1:0]  shifted_t;
  typedef logic signed [RotWidth-1:0]    rot_t;

  localparam sum_t RoundHalf = sum_t'(64'sd1 <<< (FracBits - 1));
  localparam rot_t RotMax    = {1'b0, {(RotWidth-1){1'b1}}};
  localparam rot_t RotMin    = {1'b1, {(RotWidth-1){1'b0}}};

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } vec_t;

  typedef struct packed {
    prod_t ww;
    prod_t xx;
    prod_t yy;
    prod_t zz;
    prod_t wx;
    prod_t wy;
    prod_t wz;
    prod_t xy;
    prod_t xz;
    prod_t yz;
  } prod_set_t;

  typedef struct packed {
    coef_t xx;
    coef_t xy;
    coef_t xz;
    coef_t yx;
    coef_t yy;
    coef_t yz;
    coef_t zx;
    coef_t zy;
    coef_t zz;
  } coef_set_t;

  typedef struct packed {
    term_t xa;
    term_t xb;
    term_t xc;
    term_t ya;
    term_t yb;
    term_t yc;
    term_t za;
    term_t zb;
    term_t zc;
  } term_set_t;

  function automatic rot_t saturate(input shifted_t val);
    rot_t res;
    if (val > shifted_t'(RotMax)) begin
      res = RotMax;
    end else if (val < shifted_t'(RotMin)) begin
      res = RotMin;
    end else begin
      res = val[RotWidth-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/qvr_products.sv */
// Stage 1: the ten pairwise quaternion products, registered with the vector.
// Depends on qvr_pkg.
module qvr_products import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  sample_t   qw,
  input  sample_t   qx,
  input  sample_t   qy,
  input  sample_t   qz,
  input  vec_t      vec_in,
  output logic      valid,
  output prod_set_t prods,
  output vec_t      vec
);

  prod_t ew, ex, ey, ez;

  assign ew = prod_t'(qw);
  assign ex = prod_t'(qx);
  assign ey = prod_t'(qy);
  assign ez = prod_t'(qz);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prods.ww <= ew * ew;
      prods.xx <= ex * ex;
      prods.yy <= ey * ey;
      prods.zz <= ez * ez;
      prods.wx <= ew * ex;
      prods.wy <= ew * ey;
      prods.wz <= ew * ez;
      prods.xy <= ex * ey;
      prods.xz <= ex * ez;
      prods.yz <= ey * ez;
      vec      <= vec_in;
    end
  end

endmodule

/* hdl/qvr_coef.sv */
// Stage 2: fold the products into the nine rotation matrix coefficients.
// Depends on qvr_pkg.
module qvr_coef import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  prod_set_t prods,
  input  vec_t      vec_in,
  output logic      valid,
  output coef_set_t coefs,
  output vec_t      vec
);

  coef_t ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
  coef_set_t coefs_next;

  always_comb begin
    ww = coef_t'(prods.ww);
    xx = coef_t'(prods.xx);
    yy = coef_t'(prods.yy);
    zz = coef_t'(prods.zz);
    wx = coef_t'(prods.wx);
    wy = coef_t'(prods.wy);
    wz = coef_t'(prods.wz);
    xy = coef_t'(prods.xy);
    xz = coef_t'(prods.xz);
    yz = coef_t'(prods.yz);
    coefs_next.xx = ww + xx - yy - zz;
    coefs_next.xy = (xy - wz) <<< 1;
    coefs_next.xz = (wy + xz) <<< 1;
    coefs_next.yx = (xy + wz) <<< 1;
    coefs_next.yy = ww - xx + yy - zz;
    coefs_next.yz = (yz - wx) <<< 1;
    coefs_next.zx = (xz - wy) <<< 1;
    coefs_next.zy = (yz + wx) <<< 1;
    coefs_next.zz = ww - xx - yy + zz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coefs <= coefs_next;
      vec   <= vec_in;
    end
  end

endmodule

/* hdl/qvr_scale.sv */
// Stage 3: nine coefficient-by-sample products.
// Depends on qvr_pkg.
module qvr_scale import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  coef_set_t coefs,
  input  vec_t      vec_in,
  output logic      valid,
  output term_set_t terms
);

  term_t px, py, pz;

  assign px = term_t'(vec_in.x);
  assign py = term_t'(vec_in.y);
  assign pz = term_t'(vec_in.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terms.xa <= term_t'(coefs.xx) * px;
      terms.xb <= term_t'(coefs.xy) * py;
      terms.xc <= term_t'(coefs.xz) * pz;
      terms.ya <= term_t'(coefs.yx) * px;
      terms.yb <= term_t'(coefs.yy) * py;
      terms.yc <= term_t'(coefs.yz) * pz;
      terms.za <= term_t'(coefs.zx) * px;
      terms.zb <= term_t'(coefs.zy) * py;
      terms.zc <= term_t'(coefs.zz) * pz;
    end
  end

endmodule

/* hdl/qvr_round.sv */
// Stages 4 and 5: sum with rounding offset, then shift and saturate to 18 bits.
// Depends on qvr_pkg.
module qvr_round import qvr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      valid_in,
  input  term_set_t terms,
  output logic      valid,
  output rot_t      rot_x,
  output rot_t      rot_y,
  output rot_t      rot_z
);

  logic sum_valid;
  sum_t sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      valid     <= 1'b0;
    end else if (en) begin
      sum_valid <= valid_in;
      valid     <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_x <= sum_t'(terms.xa) + sum_t'(terms.xb) + sum_t'(terms.xc) + RoundHalf;
      sum_y <= sum_t'(terms.ya) + sum_t'(terms.yb) + sum_t'(terms.yc) + RoundHalf;
      sum_z <= sum_t'(terms.za) + sum_t'(terms.zb) + sum_t'(terms.zc) + RoundHalf;
      rot_x <= saturate(sum_x[SumWidth-1:FracBits]);
      rot_y <= saturate(sum_y[SumWidth-1:FracBits]);
      rot_z <= saturate(sum_z[SumWidth-1:FracBits]);
    end
  end

endmodule

/* hdl/quaternion_vector_rotate.sv */
// Quaternion vector rotation, five-stage pipeline: products, coefficients,
// scaling, rounded sum, saturation. Throughput one word per cycle while no
// output word is stalled. A stalled output word freezes every stage.
// Synchronous active-high rst clears all valid bits; data registers are not reset.
// Depends on qvr_pkg, qvr_products, qvr_coef, qvr_scale, qvr_round.
module quaternion_vector_rotate import qvr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  sample_t quat_w,
  input  sample_t quat_x,
  input  sample_t quat_y,
  input  sample_t quat_z,
  input  sample_t vec_x,
  input  sample_t vec_y,
  input  sample_t vec_z,
  output logic    out_valid,
  input  logic    out_stall,
  output rot_t    rot_x,
  output rot_t    rot_y,
  output rot_t    rot_z
);

  logic      en;
  logic      s1_valid, s2_valid, s3_valid;
  prod_set_t s1_prods;
  vec_t      s1_vec, s2_vec, vec_in;
  coef_set_t s2_coefs;
  term_set_t s3_terms;

  assign en       = ~out_valid | ~out_stall;
  assign in_stall = ~en;
  assign vec_in   = '{x: vec_x, y: vec_y, z: vec_z};

  qvr_products u_products (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (in_valid),
    .qw       (quat_w),
    .qx       (quat_x),
    .qy       (quat_y),
    .qz       (quat_z),
    .vec_in   (vec_in),
    .valid    (s1_valid),
    .prods    (s1_prods),
    .vec      (s1_vec)
  );

  qvr_coef u_coef (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (s1_valid),
    .prods    (s1_prods),
    .vec_in   (s1_vec),
    .valid    (s2_valid),
    .coefs    (s2_coefs),
    .vec      (s2_vec)
  );

  qvr_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (s2_valid),
    .coefs    (s2_coefs),
    .vec_in   (s2_vec),
    .valid    (s3_valid),
    .terms    (s3_terms)
  );

  qvr_round u_round (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (s3_valid),
    .terms    (s3_terms),
    .valid    (out_valid),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z)
  );

endmodule

/* hdl/qvr_check.sv */
// Port-level checker for quaternion_vector_rotate, attached with a bind.
// Depends on qvr_pkg.
module qvr_check import qvr_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_stall,
  input logic    out_valid,
  input logic    out_stall,
  input rot_t    rot_x,
  input rot_t    rot_y,
  input rot_t    rot_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rot_x) && $stable(rot_y)
      && $stable(rot_z))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word valid after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("accepted word did not reach output in five cycles");

endmodule

bind quaternion_vector_rotate qvr_check u_qvr_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .rot_x     (rot_x),
  .rot_y     (rot_y),
  .rot_z     (rot_z)
);

/* verif/quaternion_vector_rotate_test.sv */
// Self-checking testbench for quaternion_vector_rotate: drives quaternion and vector words,
// predicts each rounded, saturated rotation and compares it with the output word.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module quaternion_vector_rotate_test;
  import qvr_pkg::*;

  typedef struct packed {
    rot_t x;
    rot_t y;
    rot_t z;
  } rotation_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t quat_w = '0;
  sample_t quat_x = '0;
  sample_t quat_y = '0;
  sample_t quat_z = '0;
  sample_t vec_x = '0;
  sample_t vec_y = '0;
  sample_t vec_z = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  rot_t    rot_x;
  rot_t    rot_y;
  rot_t    rot_z;

  rotation_t expected_rotations[$];
  int        failures = 0;
  bit        idle_on = 1'b1;

  quaternion_vector_rotate DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic rot_t round_saturate(input longint sum);
    longint q;
    q = (sum + (64'sd1 <<< 29)) >>> 30;
    if (q > 131071) begin
      q = 131071;
    end else if (q < -131072) begin
      q = -131072;
    end
    return rot_t'(q);
  endfunction

  function automatic rotation_t rotate_vector(input sample_t w, qx, qy, qz,
                                              input sample_t vx, vy, vz);
    longint ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint px, py, pz, sx, sy, sz;
    rotation_t r;
    ww = longint'(w) * w;
    xx = longint'(qx) * qx;
    yy = longint'(qy) * qy;
    zz = longint'(qz) * qz;
    wx = longint'(w) * qx;
    wy = longint'(w) * qy;
    wz = longint'(w) * qz;
    xy = longint'(qx) * qy;
    xz = longint'(qx) * qz;
    yz = longint'(qy) * qz;
    px = vx;
    py = vy;
    pz = vz;
    sx = (ww + xx - yy - zz) * px + 2 * (wy + xz) * pz + 2 * (xy - wz) * py;
    sy = (ww + yy - xx - zz) * py + 2 * (xy + wz) * px + 2 * (yz - wx) * pz;
    sz = (ww + zz - xx - yy) * pz + 2 * (xz - wy) * px + 2 * (yz + wx) * py;
    r.x = round_saturate(sx);
    r.y = round_saturate(sy);
    r.z = round_saturate(sz);
    return r;
  endfunction

  function automatic sample_t pick_sample();
    sample_t s;
    case ($urandom_range(0, 7))
      0: s = -16'sd32768;
      1: s = 16'sd32767;
      2: s = '0;
      3: s = sample_t'($urandom_range(0, 8)) - 16'sd4;
      default: s = sample_t'($urandom);
    endcase
    return s;
  endfunction

  function automatic sample_t pick_extreme();
    sample_t s;
    case ($urandom_range(0, 3))
      0: s = 16'sd32767;
      1: s = -16'sd32767;
      default: s = -16'sd32768;
    endcase
    return s;
  endfunction

  task automatic send_word(input sample_t w, qx, qy, qz, input sample_t vx, vy, vz);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    quat_w   <= w;
    quat_x   <= qx;
    quat_y   <= qy;
    quat_z   <= qz;
    vec_x    <= vx;
    vec_y    <= vy;
    vec_z    <= vz;
    do @(posedge clk); while (in_stall);
    expected_rotations.push_back(rotate_vector(w, qx, qy, qz, vx, vy, vz));
  endtask

  task automatic send_random_word();
    send_word(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
              pick_sample(), pick_sample(), pick_sample());
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // stall the output side in random bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rotation_t want;
    rotation_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{x: rot_x, y: rot_y, z: rot_z};
        if (expected_rotations.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected word: rot %0d %0d %0d", got.x, got.y, got.z);
          end
        end else begin
          want = expected_rotations.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: expected rot %0d %0d %0d, got %0d %0d %0d",
                       want.x, want.y, want.z, got.x, got.y, got.z);
            end
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_word(0, 0, 0, 0, 0, 0, 0);
    send_word(16'sd32767, 0, 0, 0, 16'sd1000, -16'sd2000, 16'sd3000);
    send_word(-16'sd32768, 0, 0, 0, 16'sd32767, -16'sd32768, 16'sd1);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
              -16'sd32768, -16'sd32768, -16'sd32768);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
              16'sd32767, 16'sd32767, 16'sd32767);
    // drive rot_y past the positive limit
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
              16'sd32767, 16'sd32767, -16'sd32768);
    send_word(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
              -16'sd32768, -16'sd32768, 16'sd32767);
    // ties at +0.5, -0.5 and -1.5
    send_word(16'sd16384, 0, 0, 0, 16'sd2, 0, 0);
    send_word(16'sd16384, 0, 0, 0, -16'sd2, 0, 0);
    send_word(16'sd16384, 0, 0, 0, -16'sd6, 0, 0);
    send_word(0, 16'sd16384, 0, 0, 16'sd2, -16'sd2, -16'sd6);
    send_word(0, 0, 16'sd16384, 16'sd16384, 16'sd3, -16'sd5, 16'sd7);
    send_word(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_word(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_word(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_word(16'sd23170, 0, 0, 16'sd23170, 16'sd12345, -16'sd23456, 16'sd31000);
    send_word(16'sd23170, 16'sd23170, 0, 0, 16'sd32767, 16'sd32767, -16'sd32768);
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic test_extreme_quaternions(input int count);
    repeat (count) begin
      send_word(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  task automatic test_drain_pause(input int count);
    repeat (count) send_random_word();
    hold_input();
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (count) send_random_word();
  endtask

  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    repeat (count) send_random_word();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_stream(700);
    test_extreme_quaternions(150);
    test_drain_pause(50);
    test_back_to_back(100);
    hold_input();
    while (expected_rotations.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/qvr_pkg.sv
hdl/qvr_products.sv
hdl/qvr_coef.sv
hdl/qvr_scale.sv
hdl/qvr_round.sv
hdl/quaternion_vector_rotate.sv
hdl/qvr_check.sv
verif/quaternion_vector_rotate_test.sv
